// ===== sv/sdt_pkg.sv =====
// Shared types and constants of the seen-device table.
// Used by every module of the block but the row memory; depends on nothing.
`default_nettype none

package sdt_pkg;

    // Field widths fixed by the item format.
    localparam int ADDR_W     = 48;
    localparam int KIND_W     = 2;
    localparam int RSSI_W     = 8;
    localparam int APP_W      = 16;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 32;
    localparam int SLOT_W     = 6;
    localparam int TALLY_W    = 7;

    // Default table size and register reset value (30 minutes in ms).
    localparam int            TABLE_DEPTH_DEF = 64;
    localparam logic [31:0]   STALE_RESET     = 32'(30 * 60 * 1000);

    // Register port geometry: one 32-bit register at byte address 0.
    localparam int            PADDR_W         = 3;
    localparam logic [0:0]    REG_STALE_LIMIT = 1'b0;

    // Mode codes of an input item.
    localparam logic MODE_SIGHTING = 1'b0;
    localparam logic MODE_PRUNE    = 1'b1;

    // One input item.
    typedef struct packed {
        logic                     mode;
        logic [ADDR_W-1:0]        dev_address;
        logic [KIND_W-1:0]        address_kind;
        logic signed [RSSI_W-1:0] signal_strength;
        logic [APP_W-1:0]         appearance_code;
        logic                     can_connect;
        logic [TIME_W-1:0]        now_ms;
    } item_t;

    // One stored table row.
    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [KIND_W-1:0]  kind;
        logic [RSSI_W-1:0]  strength;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  last_seen;
        logic [APP_W-1:0]   appearance;
        logic               connectable;
    } row_t;

    // One result item.
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               was_new;
        logic               was_evicted;
        logic [COUNT_W-1:0] sighting_total;
        logic [TALLY_W-1:0] removed;
        logic [TALLY_W-1:0] occupancy;
    } res_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PRUNE
    } state_t;

endpackage

`default_nettype wire

// ===== sv/seen_device_table_lru_aging_unit.sv =====
// Seen-device table with least-recently-seen eviction and stale-row pruning.
// A sighting reads the live rows in order until one matches; a miss reads every live row
// and then appends or evicts; a prune tests every live row.
// A new item is accepted only while the block is idle; each row test, including the retest of a row moved
// into a hole, takes one read of the row memory. The receiver cannot stall a result.
// Reset empties the table and sets the stale limit to 30 minutes; row memory is not cleared.
`default_nettype none

module seen_device_table_lru_aging_unit #(
    parameter int TABLE_DEPTH = sdt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        mode,
    input  wire logic [47:0]                 dev_address,
    input  wire logic [1:0]                  address_kind,
    input  wire logic signed [7:0]           signal_strength,
    input  wire logic [15:0]                 appearance_code,
    input  wire logic                        can_connect,
    input  wire logic [31:0]                 now_ms,
    output logic                             done,
    output logic      [5:0]                  slot,
    output logic                             was_new,
    output logic                             was_evicted,
    output logic      [31:0]                 sighting_total,
    output logic      [6:0]                  removed,
    output logic      [6:0]                  occupancy,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sdt_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);
    import sdt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    item_t            item;
    row_t             ram_rdata;
    row_t             ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [IDX_W-1:0] ram_waddr;
    logic             ram_we;
    logic [31:0]      stale_limit;
    logic             res_vld;
    res_t             res;
    logic             done_reg;
    res_t             res_reg;

    // Gather the item fields.
    always_comb
    begin
        item.mode            = mode;
        item.dev_address     = dev_address;
        item.address_kind    = address_kind;
        item.signal_strength = signal_strength;
        item.appearance_code = appearance_code;
        item.can_connect     = can_connect;
        item.now_ms          = now_ms;
    end

    sdt_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .stale_limit (stale_limit)
    );

    sdt_ram #(
        .WIDTH ($bits(row_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sdt_engine #(
        .DEPTH (TABLE_DEPTH)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .item        (item),
        .stale_limit (stale_limit),
        .busy        (busy),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .res_vld     (res_vld),
        .res         (res)
    );

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_vld;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (res_vld)
        begin
            res_reg <= res;
        end
    end

    assign done           = done_reg;
    assign slot           = res_reg.slot;
    assign was_new        = res_reg.was_new;
    assign was_evicted    = res_reg.was_evicted;
    assign sighting_total = res_reg.sighting_total;
    assign removed        = res_reg.removed;
    assign occupancy      = res_reg.occupancy;

`ifndef SYNTH
    // An accepted item keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not make the block busy");

    // A result only follows a cycle of work.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without preceding work");

    // An eviction always creates a new row.
    a_evict_new: assert property (@(posedge clk) disable iff (!rst_n)
        done && was_evicted |-> was_new)
        else $error("eviction reported without a new row");

    // A prune that removed rows reports no sighting fields.
    a_prune_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && (removed != 7'd0) |-> !was_new && (slot == 6'd0) && (sighting_total == 32'd0))
        else $error("prune result carries sighting fields");
`endif

endmodule

`default_nettype wire

// ===== sv/sdt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package needed.
`default_nettype none

module sdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/sdt_regs.sv =====
// Register port of the seen-device table: holds the stale age limit.
// Depends on sdt_pkg for the address map and reset value.
`default_nettype none

module sdt_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sdt_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output logic      [31:0]                 stale_limit
);
    import sdt_pkg::*;

    logic [31:0] stale_reg;
    logic [0:0]  reg_sel;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // The limit register takes a write in the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_reg <= STALE_RESET;
        end
        else if (wr_en && (reg_sel == REG_STALE_LIMIT))
        begin
            stale_reg <= pwdata;
        end
    end

    // Read decode.
    always_comb
    begin
        unique case (reg_sel)
            REG_STALE_LIMIT: prdata = stale_reg;
            default:         prdata = 32'd0;
        endcase
    end

    assign stale_limit = stale_reg;

endmodule

`default_nettype wire

// ===== sv/sdt_engine.sv =====
// Sequencer of the seen-device table: scans rows in the row memory, updates,
// appends, evicts and prunes. Depends on sdt_pkg.
`default_nettype none

module sdt_engine #(
    parameter int  DEPTH  = sdt_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_W  = $clog2(DEPTH),
    localparam int CNT_W  = $clog2(DEPTH + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire sdt_pkg::item_t       item,
    input  wire logic [31:0]          stale_limit,
    output logic                      busy,
    output logic      [IDX_W-1:0]     ram_raddr,
    input  wire sdt_pkg::row_t        ram_rdata,
    output logic                      ram_we,
    output logic      [IDX_W-1:0]     ram_waddr,
    output sdt_pkg::row_t             ram_wdata,
    output logic                      res_vld,
    output sdt_pkg::res_t             res
);
    import sdt_pkg::*;

    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    state_t              state_reg,   state_next;
    item_t               item_reg,    item_next;
    logic [CNT_W-1:0]    live_reg,    live_next;
    logic [CNT_W-1:0]    removed_reg, removed_next;
    logic [CNT_W-1:0]    rd_idx_reg,  rd_idx_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                chk_vld_reg, chk_vld_next;
    logic                move_reg,    move_next;
    logic [TIME_W-1:0]   min_reg,     min_next;
    logic [IDX_W-1:0]    min_idx_reg, min_idx_next;

    logic [CNT_W-1:0]    chk_ext;
    logic [CNT_W-1:0]    chk_inc;
    logic [CNT_W-1:0]    live_dec;
    logic [TIME_W-1:0]   age;
    logic                stale;
    logic                issue;
    logic                hit;
    logic                full;
    row_t                row_upd;
    row_t                row_new;

    assign chk_ext  = CNT_W'(chk_idx_reg);
    assign chk_inc  = chk_ext + ONE;
    assign live_dec = live_reg - ONE;
    assign age      = item_reg.now_ms - ram_rdata.last_seen;
    assign stale    = age > stale_limit;
    assign issue    = rd_idx_reg < live_reg;
    assign hit      = chk_vld_reg && (ram_rdata.address == item_reg.dev_address);
    assign full     = live_reg == FULL;
    assign busy     = state_reg != ST_IDLE;

    // Row contents after a sighting of a known device.
    always_comb
    begin
        row_upd             = ram_rdata;
        row_upd.kind        = item_reg.address_kind;
        row_upd.strength    = item_reg.signal_strength;
        row_upd.count       = ram_rdata.count + COUNT_W'(1);
        row_upd.last_seen   = item_reg.now_ms;
        row_upd.connectable = item_reg.can_connect;
        if (item_reg.appearance_code != '0)
        begin
            row_upd.appearance = item_reg.appearance_code;
        end
    end

    // Row contents for a device that is new to the table.
    always_comb
    begin
        row_new.address     = item_reg.dev_address;
        row_new.kind        = item_reg.address_kind;
        row_new.strength    = item_reg.signal_strength;
        row_new.count       = COUNT_W'(1);
        row_new.last_seen   = item_reg.now_ms;
        row_new.appearance  = item_reg.appearance_code;
        row_new.connectable = item_reg.can_connect;
    end

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            live_reg    <= '0;
            chk_vld_reg <= 1'b0;
            move_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            live_reg    <= live_next;
            chk_vld_reg <= chk_vld_next;
            move_reg    <= move_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        removed_reg <= removed_next;
        rd_idx_reg  <= rd_idx_next;
        chk_idx_reg <= chk_idx_next;
        min_reg     <= min_next;
        min_idx_reg <= min_idx_next;
    end

    // Next state, memory access and result.
    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        live_next    = live_reg;
        removed_next = removed_reg;
        rd_idx_next  = rd_idx_reg;
        chk_idx_next = chk_idx_reg;
        chk_vld_next = chk_vld_reg;
        move_next    = move_reg;
        min_next     = min_reg;
        min_idx_next = min_idx_reg;
        ram_raddr    = '0;
        ram_we       = 1'b0;
        ram_waddr    = chk_idx_reg;
        ram_wdata    = row_new;
        res_vld      = 1'b0;
        res          = '0;
        res.occupancy = TALLY_W'(live_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                // Row 0 is read ahead so the first check runs in the next cycle.
                ram_raddr = '0;
                if (start)
                begin
                    item_next    = item;
                    chk_idx_next = '0;
                    chk_vld_next = live_reg != '0;
                    rd_idx_next  = ONE;
                    removed_next = '0;
                    move_next    = 1'b0;
                    state_next   = (item.mode == MODE_PRUNE) ? ST_PRUNE : ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                ram_raddr = rd_idx_reg[IDX_W-1:0];
                if (hit)
                begin
                    // Known device: update its row in place.
                    ram_we             = 1'b1;
                    ram_waddr          = chk_idx_reg;
                    ram_wdata          = row_upd;
                    res_vld            = 1'b1;
                    res.slot           = SLOT_W'(chk_idx_reg);
                    res.sighting_total = row_upd.count;
                    chk_vld_next       = 1'b0;
                    state_next         = ST_IDLE;
                end
                else if (!chk_vld_reg && !issue)
                begin
                    // All live rows checked: append, or reuse the oldest row.
                    ram_we             = 1'b1;
                    ram_waddr          = full ? min_idx_reg : live_reg[IDX_W-1:0];
                    ram_wdata          = row_new;
                    live_next          = full ? live_reg : live_reg + ONE;
                    res_vld            = 1'b1;
                    res.slot           = SLOT_W'(ram_waddr);
                    res.was_new        = 1'b1;
                    res.was_evicted    = full;
                    res.sighting_total = row_new.count;
                    res.occupancy      = TALLY_W'(live_next);
                    state_next         = ST_IDLE;
                end
                else
                begin
                    // Track the oldest row; the lowest index wins ties.
                    if (chk_vld_reg &&
                        ((chk_idx_reg == '0) || (ram_rdata.last_seen < min_reg)))
                    begin
                        min_next     = ram_rdata.last_seen;
                        min_idx_next = chk_idx_reg;
                    end
                    chk_vld_next = issue;
                    chk_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next  = rd_idx_reg + CNT_W'(issue);
                end
            end

            ST_PRUNE:
            begin
                // A row fetched from the end is written into the hole first.
                ram_we    = move_reg && chk_vld_reg;
                ram_waddr = chk_idx_reg;
                ram_wdata = ram_rdata;
                if (!chk_vld_reg)
                begin
                    res_vld       = 1'b1;
                    res.removed   = TALLY_W'(removed_reg);
                    state_next    = ST_IDLE;
                end
                else if (stale)
                begin
                    live_next    = live_dec;
                    removed_next = removed_reg + ONE;
                    if (chk_ext == live_dec)
                    begin
                        // The last live row was the stale one.
                        res_vld       = 1'b1;
                        res.removed   = TALLY_W'(removed_next);
                        res.occupancy = TALLY_W'(live_next);
                        chk_vld_next  = 1'b0;
                        move_next     = 1'b0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        // Fetch the last live row and retest it at this index.
                        ram_raddr = live_dec[IDX_W-1:0];
                        move_next = 1'b1;
                    end
                end
                else if (chk_inc < live_reg)
                begin
                    ram_raddr    = chk_inc[IDX_W-1:0];
                    chk_idx_next = chk_inc[IDX_W-1:0];
                    move_next    = 1'b0;
                end
                else
                begin
                    res_vld      = 1'b1;
                    res.removed  = TALLY_W'(removed_reg);
                    chk_vld_next = 1'b0;
                    move_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sim/seen_device_table_lru_aging_checker.sv =====
`timescale 1ns / 100ps
// Checker for the seen-device table: watches the item, result and register channels,
// predicts each result from its own copy of the table, and counts mismatches. Needs sdt_pkg.
module seen_device_table_lru_aging_checker #(
    parameter int DEPTH = sdt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        mode,
    input  logic [47:0]                 dev_address,
    input  logic [1:0]                  address_kind,
    input  logic signed [7:0]           signal_strength,
    input  logic [15:0]                 appearance_code,
    input  logic                        can_connect,
    input  logic [31:0]                 now_ms,
    input  logic                        done,
    input  logic [5:0]                  slot,
    input  logic                        was_new,
    input  logic                        was_evicted,
    input  logic [31:0]                 sighting_total,
    input  logic [6:0]                  removed,
    input  logic [6:0]                  occupancy,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sdt_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    output int                          fail_count,
    output int                          outstanding,
    output int                          n_items,
    output int                          n_prunes,
    output int                          n_dropped,
    output int                          n_evictions
);
    import sdt_pkg::*;

    localparam logic [PADDR_W-1:0] STALE_ADDR = PADDR_W'({REG_STALE_LIMIT, 2'b00});

    // Shadow copy of the device table and its register.
    row_t        rows [DEPTH];
    int unsigned live;
    logic [31:0] stale_limit;

    // Results predicted for accepted items, oldest first.
    res_t        awaited_reports [$];
    int          mismatches;
    int          items_seen;
    int          prunes_seen;
    int          rows_dropped;
    int          evictions_seen;

    // Applies one item to the shadow table and returns the report it should produce.
    function automatic res_t table_step(input item_t it);
        res_t        r;
        int unsigned i;
        int unsigned hit;
        bit          found;
        logic [31:0] age;
        r = '0;
        if (it.mode == MODE_PRUNE) begin
            // Stale rows are replaced by the last live row, which is then tested in turn.
            i = 0;
            while (i < live) begin
                age = it.now_ms - rows[i].last_seen;
                if (age > stale_limit) begin
                    live = live - 1;
                    rows[i] = rows[live];
                    r.removed = r.removed + 1'b1;
                end
                else begin
                    i = i + 1;
                end
            end
        end
        else begin
            found = 1'b0;
            hit = 0;
            for (i = 0; i < live; i++) begin
                if (!found && rows[i].address == it.dev_address) begin
                    hit = i;
                    found = 1'b1;
                end
            end
            // A miss appends a row, or reuses the row seen longest ago when the table is full.
            if (!found) begin
                r.was_new = 1'b1;
                if (live < DEPTH) begin
                    hit = live;
                    live = live + 1;
                end
                else begin
                    hit = 0;
                    for (i = 1; i < DEPTH; i++) begin
                        if (rows[i].last_seen < rows[hit].last_seen)
                            hit = i;
                    end
                    r.was_evicted = 1'b1;
                end
                rows[hit] = '0;
                rows[hit].address = it.dev_address;
            end
            rows[hit].kind = it.address_kind;
            rows[hit].strength = it.signal_strength;
            rows[hit].count = rows[hit].count + 1'b1;
            rows[hit].last_seen = it.now_ms;
            if (it.appearance_code != '0)
                rows[hit].appearance = it.appearance_code;
            rows[hit].connectable = it.can_connect;
            r.slot = SLOT_W'(hit);
            r.sighting_total = rows[hit].count;
        end
        r.occupancy = TALLY_W'(live);
        return r;
    endfunction

    function automatic void compare_field(input string name, input longint unsigned want,
                                          input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Register writes, result checks and item predictions, all sampled at the rising edge.
    always @(posedge clk or negedge rst_n) begin : watch
        item_t it;
        res_t  want;
        res_t  got;
        if (!rst_n) begin
            live = 0;
            stale_limit = STALE_RESET;
            awaited_reports.delete();
            mismatches = 0;
            items_seen = 0;
            prunes_seen = 0;
            rows_dropped = 0;
            evictions_seen = 0;
        end
        else begin
            if (psel && penable && pwrite && pready && paddr == STALE_ADDR)
                stale_limit = pwdata;

            // The oldest prediction is retired before a new item can add one.
            if (done) begin
                got = '{slot, was_new, was_evicted, sighting_total, removed, occupancy};
                if (awaited_reports.size() == 0) begin
                    $error("result with no item pending: slot %0d occupancy %0d",
                           slot, occupancy);
                    mismatches++;
                end
                else begin
                    want = awaited_reports.pop_front();
                    compare_field("slot", want.slot, got.slot);
                    compare_field("was_new", want.was_new, got.was_new);
                    compare_field("was_evicted", want.was_evicted, got.was_evicted);
                    compare_field("sighting_total", want.sighting_total, got.sighting_total);
                    compare_field("removed", want.removed, got.removed);
                    compare_field("occupancy", want.occupancy, got.occupancy);
                end
            end

            if (start && !busy) begin
                it = '{mode, dev_address, address_kind, signal_strength,
                       appearance_code, can_connect, now_ms};
                want = table_step(it);
                awaited_reports.push_back(want);
                items_seen++;
                if (it.mode == MODE_PRUNE)
                    prunes_seen++;
                rows_dropped += want.removed;
                evictions_seen += want.was_evicted;
            end
        end
        fail_count <= mismatches;
        outstanding <= awaited_reports.size();
        n_items <= items_seen;
        n_prunes <= prunes_seen;
        n_dropped <= rows_dropped;
        n_evictions <= evictions_seen;
    end

endmodule

// ===== sim/seen_device_table_lru_aging_unit_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the seen-device table: clock, reset, register writes and item stimulus.
// Depends on sdt_pkg, seen_device_table_lru_aging_unit and the checker module beside it.
module seen_device_table_lru_aging_unit_test;
    import sdt_pkg::*;

    localparam logic [PADDR_W-1:0] STALE_ADDR = PADDR_W'({REG_STALE_LIMIT, 2'b00});
    localparam int POOL_SIZE    = 96;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 100;
    localparam int DRAIN_CYCLES = 140;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               mode = MODE_SIGHTING;
    logic [47:0]        dev_address = '0;
    logic [1:0]         address_kind = '0;
    logic signed [7:0]  signal_strength = '0;
    logic [15:0]        appearance_code = '0;
    logic               can_connect = 1'b0;
    logic [31:0]        now_ms = '0;
    logic               done;
    logic [5:0]         slot;
    logic               was_new;
    logic               was_evicted;
    logic [31:0]        sighting_total;
    logic [6:0]         removed;
    logic [6:0]         occupancy;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int fail_count;
    int outstanding;
    int n_items;
    int n_prunes;
    int n_dropped;
    int n_evictions;

    int unsigned idle_pct;
    int          limit_writes;

    seen_device_table_lru_aging_unit u_top (.*);

    seen_device_table_lru_aging_checker u_checker (.*);

    initial begin
        forever #2 clk = ~clk;
    end

    // Presents one item and holds it until the block takes it, then maybe idles a while.
    task automatic send(input item_t it);
        start <= 1'b1;
        mode <= it.mode;
        dev_address <= it.dev_address;
        address_kind <= it.address_kind;
        signal_strength <= it.signal_strength;
        appearance_code <= it.appearance_code;
        can_connect <= it.can_connect;
        now_ms <= it.now_ms;
        @(posedge clk);
        while (busy) @(posedge clk);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct) @(posedge clk);
        end
    endtask

    task automatic sight(input logic [47:0] a, input logic [1:0] k,
                         input logic signed [7:0] s, input logic [15:0] ap,
                         input logic c, input logic [31:0] t);
        send('{MODE_SIGHTING, a, k, s, ap, c, t});
    endtask

    // A prune carries random content in the fields it does not use.
    task automatic prune(input logic [31:0] t);
        send('{MODE_PRUNE, 48'({$urandom, $urandom}), 2'($urandom), 8'($urandom),
               16'($urandom), 1'($urandom), t});
    endtask

    // Stops issuing and waits until every predicted result has come back.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_stale_limit(input logic [31:0] v);
        settle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= STALE_ADDR;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        limit_writes++;
    endtask

    initial begin
        logic [47:0] pool [POOL_SIZE];
        logic [31:0] limits [PHASES];
        int unsigned idle_plan [PHASES];
        logic [31:0] clock_ms;
        logic [47:0] pick;
        limit_writes = 0;
        idle_pct = 50;
        for (int i = 0; i < POOL_SIZE; i++)
            pool[i] = 48'({$urandom, $urandom});
        limits[0] = $urandom_range(200000, 20000);
        limits[1] = '0;
        limits[2] = 32'hFFFF_FFFF;
        limits[3] = $urandom_range(50000, 1000);
        limits[4] = $urandom;
        idle_plan = '{0, 87, 10, 0, 87};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset limit: empty prune, field extremes, hits.
        prune(32'd0);
        sight(48'h0, 2'd0, -8'sd128, 16'h0, 1'b0, 32'd0);
        sight(48'hFFFF_FFFF_FFFF, 2'd3, 8'sd127, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        sight(48'h0, 2'd1, 8'sd0, 16'd1234, 1'b1, 32'd10);
        // A zero appearance code keeps the stored one.
        sight(48'h0, 2'd2, -8'sd1, 16'h0, 1'b0, 32'd20);
        sight(48'h5555_5555_5555, 2'd2, 8'sd1, 16'hAAAA, 1'b0, 32'h5555_5555);
        sight(48'hAAAA_AAAA_AAAA, 2'd1, -8'sd2, 16'h5555, 1'b1, 32'hAAAA_AAAA);
        // An age exactly at the limit survives; one past it is dropped.
        prune(STALE_RESET + 32'd20);
        prune(STALE_RESET + 32'd21);
        prune(32'hFFFF_FFFF);

        // A zero limit drops every row with a non-zero age.
        set_stale_limit('0);
        sight(48'h1234_5678_9ABC, 2'd0, 8'sd5, 16'h0, 1'b1, 32'd100);
        sight(48'hFEDC_BA98_7654, 2'd3, -8'sd5, 16'h0042, 1'b0, 32'd101);
        prune(32'd101);
        prune(32'd102);

        // The largest limit never drops anything.
        set_stale_limit(32'hFFFF_FFFF);
        sight(48'h0000_0000_0001, 2'd1, 8'sd3, 16'h0, 1'b0, 32'd5);
        prune(32'd4);
        prune(32'hFFFF_FFF0);

        // Random part: a pool of recurring addresses fills the table so it evicts,
        // with occasional strangers, prunes and jumps of the clock.
        clock_ms = $urandom;
        for (int p = 0; p < PHASES; p++) begin
            set_stale_limit(limits[p]);
            idle_pct = idle_plan[p];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 3)
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms + $urandom_range(3000, 0);
                if ($urandom_range(99) < 8) begin
                    prune(clock_ms);
                end
                else begin
                    if ($urandom_range(9) == 0)
                        pick = 48'({$urandom, $urandom});
                    else
                        pick = pool[$urandom_range(POOL_SIZE - 1, 0)];
                    sight(pick, 2'($urandom), 8'($urandom),
                          ($urandom_range(2, 0) == 0) ? 16'h0 : 16'($urandom),
                          1'($urandom), clock_ms);
                end
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d items over %0d stale-limit settings: %0d prunes dropped %0d rows,",
                 n_items, limit_writes, n_prunes, n_dropped);
        $display("and %0d sightings evicted the oldest row.", n_evictions);
        if (fail_count == 0)
            $display("seen_device_table_lru_aging_unit: match");
        else
            $display("seen_device_table_lru_aging_unit: mismatch");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("seen_device_table_lru_aging_unit: mismatch");
        $finish;
    end

endmodule
